### design/dda_pkg.sv
// Shared types and constants for the DDA line rasterizer.
`default_nettype none

package dda_pkg;

    localparam int COORD_BITS  = 10;
    localparam int FRAC_BITS   = 16;
    localparam int ACC_BITS    = COORD_BITS + FRAC_BITS;
    localparam int SLOPE_BITS  = FRAC_BITS + 2;
    localparam int QUO_BITS    = FRAC_BITS + 1;
    localparam int CNT_BITS    = $clog2(QUO_BITS);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    localparam logic ACT_START = 1'b0;
    localparam logic ACT_STEP  = 1'b1;

    typedef logic [COORD_BITS-1:0] coord_t;

    typedef struct packed {
        logic   action;
        coord_t x_start;
        coord_t y_start;
        coord_t x_end;
        coord_t y_end;
    } item_t;

    typedef struct packed {
        coord_t point_x;
        coord_t point_y;
        logic   last;
    } point_t;

    typedef struct packed {
        logic   start;
        coord_t mdiff;
        coord_t span;
    } div_req_t;

    typedef struct packed {
        logic                done;
        logic [QUO_BITS-1:0] quo;
    } div_rsp_t;

    typedef enum logic {
        BK_IDLE,
        BK_DIV
    } back_state_t;

endpackage

`default_nettype wire

### design/dda_line_rasterizer.sv
// Top level of the DDA line rasterizer: front queue, slope divider and back end.
//
//  channel   handshake                 payload   direction
//  item      item_valid / item_stall   item_t    into block
//  point     point_valid / point_stall point_t   out of block
//
// A step transaction on an active line yields one point; steps run one per cycle
// unless the output stalls or a division runs. A start transaction holds the back end
// in BK_DIV while the one-bit-per-cycle slope divider runs; a degenerate start skips it.
// A two-entry queue lets the front keep accepting while the back end divides or stalls.
// Reset clears all control state; no clearing pass is needed.
`default_nettype none

module dda_line_rasterizer (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            item_valid,
    output logic                 item_stall,
    input  wire dda_pkg::item_t  item,
    output logic                 point_valid,
    input  wire logic            point_stall,
    output dda_pkg::point_t      point
);
    import dda_pkg::*;

    logic     head_valid;
    item_t    head;
    logic     head_pop;
    div_req_t div_req;
    div_rsp_t div_rsp;

    dda_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .head_valid (head_valid),
        .head       (head),
        .head_pop   (head_pop)
    );

    dda_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    dda_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_valid  (head_valid),
        .head        (head),
        .head_pop    (head_pop),
        .div_req     (div_req),
        .div_rsp     (div_rsp),
        .point_valid (point_valid),
        .point_stall (point_stall),
        .point       (point)
    );

endmodule

`default_nettype wire

### design/dda_front.sv
// Front end: accepts transactions into a short queue ahead of the back end.
`default_nettype none

module dda_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          item_valid,
    output logic               item_stall,
    input  wire dda_pkg::item_t item,
    output logic               head_valid,
    output dda_pkg::item_t     head,
    input  wire logic          head_pop
);
    import dda_pkg::*;

    item_t                entry_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_BITS-1:0] count_reg, count_next;
    logic                 push;
    logic                 pop;

    assign item_stall = (count_reg == QCNT_BITS'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = entry_reg[rd_ptr_reg];
    assign push       = item_valid && !item_stall;
    assign pop        = head_pop && head_valid;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= item;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_BITS'(QUEUE_DEPTH))
        else $error("queue count above depth");

endmodule

`default_nettype wire

### design/dda_div.sv
// Restoring divider producing the fixed-point slope one quotient bit per cycle.
`default_nettype none

module dda_div (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire dda_pkg::div_req_t req,
    output dda_pkg::div_rsp_t      rsp
);
    import dda_pkg::*;

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic [COORD_BITS:0] rem_reg, rem_next;
    logic [QUO_BITS-1:0] quo_reg, quo_next;
    coord_t              span_reg, span_next;
    logic [COORD_BITS:0] trial;
    logic                fits;

    always_comb
    begin
        trial = (cnt_reg == CNT_BITS'(QUO_BITS - 1)) ? rem_reg
                                                     : {rem_reg[COORD_BITS-1:0], 1'b0};
        fits  = (trial >= {1'b0, span_reg});
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        span_next = span_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_BITS'(QUO_BITS - 1);
            rem_next  = {1'b0, req.mdiff};
            quo_next  = '0;
            span_next = req.span;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? trial - {1'b0, span_reg} : trial;
            quo_next = {quo_reg[QUO_BITS-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        span_reg <= span_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> ($past(busy_reg) && !busy_reg))
        else $error("divider done without a running division");

    a_quo_bound: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (quo_reg <= (QUO_BITS'(1) << FRAC_BITS)))
        else $error("slope magnitude above one");

endmodule

`default_nettype wire

### design/dda_back.sv
// Back end: line setup, slope division control, point stepping and output register.
`default_nettype none

module dda_back (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              head_valid,
    input  wire dda_pkg::item_t    head,
    output logic                   head_pop,
    output dda_pkg::div_req_t      div_req,
    input  wire dda_pkg::div_rsp_t div_rsp,
    output logic                   point_valid,
    input  wire logic              point_stall,
    output dda_pkg::point_t        point
);
    import dda_pkg::*;

    back_state_t                 state_reg, state_next;
    coord_t                      major_reg, major_next;
    logic [ACC_BITS-1:0]         acc_reg, acc_next;
    logic signed [SLOPE_BITS-1:0] slope_reg, slope_next;
    coord_t                      steps_reg, steps_next;
    logic                        swapped_reg, swapped_next;
    logic                        down_reg, down_next;
    logic                        active_reg, active_next;
    logic                        out_valid_reg, out_valid_next;
    point_t                      out_reg, out_next;

    coord_t                      dx, dy, a1r, b1r, a2r, b2r, a1, b1, a2, b2;
    coord_t                      span, mdiff;
    logic                        swap, rev, down;
    logic                        is_start, is_step, out_free;
    logic                        pop_start, pop_step, emit;
    coord_t                      major_adv, minor;
    logic [ACC_BITS-1:0]         acc_adv;
    logic [SLOPE_BITS-1:0]       quo_ext;

    always_comb
    begin
        dx   = (head.x_start > head.x_end) ? head.x_start - head.x_end
                                           : head.x_end - head.x_start;
        dy   = (head.y_start > head.y_end) ? head.y_start - head.y_end
                                           : head.y_end - head.y_start;
        swap = (dx < dy);
        a1r  = swap ? head.y_start : head.x_start;
        b1r  = swap ? head.x_start : head.y_start;
        a2r  = swap ? head.y_end   : head.x_end;
        b2r  = swap ? head.x_end   : head.y_end;
        rev  = (a2r < a1r);
        a1   = rev ? a2r : a1r;
        b1   = rev ? b2r : b1r;
        a2   = rev ? a1r : a2r;
        b2   = rev ? b1r : b2r;
        span = a2 - a1;
        down = (b2 < b1);
        mdiff = down ? b1 - b2 : b2 - b1;
    end

    always_comb
    begin
        major_adv = major_reg + 1'b1;
        acc_adv   = acc_reg + {{(ACC_BITS - SLOPE_BITS){slope_reg[SLOPE_BITS-1]}}, slope_reg};
        minor     = acc_adv[ACC_BITS-1:FRAC_BITS];
        quo_ext   = {1'b0, div_rsp.quo};
    end

    assign is_start = head_valid && (head.action == ACT_START);
    assign is_step  = head_valid && (head.action == ACT_STEP);
    assign out_free = !out_valid_reg || !point_stall;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (is_start && (span != '0))
                begin
                    state_next = BK_DIV;
                end
            end
            BK_DIV:
            begin
                if (div_rsp.done)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb
    begin
        pop_start = 1'b0;
        pop_step  = 1'b0;
        unique case (state_reg)
            BK_IDLE:
            begin
                pop_start = is_start;
                pop_step  = is_step && out_free;
            end
            BK_DIV:
            begin
                pop_start = 1'b0;
                pop_step  = 1'b0;
            end
            default:
            begin
                pop_start = 1'b0;
                pop_step  = 1'b0;
            end
        endcase
    end

    assign head_pop      = pop_start || pop_step;
    assign emit          = pop_step && active_reg;
    assign div_req.start = pop_start && (span != '0);
    assign div_req.mdiff = mdiff;
    assign div_req.span  = span;

    always_comb
    begin
        major_next     = major_reg;
        acc_next       = acc_reg;
        slope_next     = slope_reg;
        steps_next     = steps_reg;
        swapped_next   = swapped_reg;
        down_next      = down_reg;
        active_next    = active_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && point_stall;
        if (pop_start)
        begin
            major_next   = a1;
            acc_next     = {b1, 1'b1, {(FRAC_BITS - 1){1'b0}}};
            steps_next   = span;
            swapped_next = swap;
            down_next    = down;
            active_next  = 1'b0;
        end
        else if (state_reg == BK_DIV && div_rsp.done)
        begin
            slope_next  = down_reg ? -$signed(quo_ext) : $signed(quo_ext);
            active_next = 1'b1;
        end
        else if (emit)
        begin
            major_next       = major_adv;
            acc_next         = acc_adv;
            steps_next       = steps_reg - 1'b1;
            active_next      = (steps_reg != coord_t'(1));
            out_valid_next   = 1'b1;
            out_next.point_x = swapped_reg ? minor : major_adv;
            out_next.point_y = swapped_reg ? major_adv : minor;
            out_next.last    = (steps_reg == coord_t'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            major_reg     <= '0;
            acc_reg       <= '0;
            slope_reg     <= '0;
            steps_reg     <= '0;
            swapped_reg   <= 1'b0;
            down_reg      <= 1'b0;
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            major_reg     <= major_next;
            acc_reg       <= acc_next;
            slope_reg     <= slope_next;
            steps_reg     <= steps_next;
            swapped_reg   <= swapped_next;
            down_reg      <= down_next;
            active_reg    <= active_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign point_valid = out_valid_reg;
    assign point       = out_reg;

    a_active_has_steps: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> (steps_reg != '0))
        else $error("active line with no steps left");

    a_div_inactive: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_DIV) |-> !active_reg)
        else $error("line active during slope division");

    a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == BK_DIV))
        else $error("slope result outside division state");

endmodule

`default_nettype wire

### bench/tb_dda_line_rasterizer.sv
// Self-checking testbench for the DDA line rasterizer: directed and random lines against a predictor.
`default_nettype none

module tb_dda_line_rasterizer;

    timeunit 1ns;
    timeprecision 1ps;

    import dda_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 600000;
    localparam int unsigned DRAIN_CYCLES = 60;
    localparam int unsigned RANDOM_ITEMS = 1350;
    localparam int unsigned COORD_MAX    = (1 << COORD_BITS) - 1;

    logic   clk         = 1'b0;
    logic   rst_n       = 1'b0;
    logic   item_valid  = 1'b0;
    logic   item_stall;
    item_t  item        = '0;
    logic   point_valid;
    logic   point_stall = 1'b0;
    point_t point;

    int unsigned idle_pct  = 37;
    int unsigned stall_pct = 37;
    int unsigned error_count  = 0;
    int unsigned cycle_count  = 0;
    int unsigned sent_items   = 0;

    point_t expected_points[$];

    // rasterizer state mirror
    coord_t      ras_major   = '0;
    longint      ras_acc     = 0;
    longint      ras_slope   = 0;
    int unsigned ras_left    = 0;
    logic        ras_swapped = 1'b0;
    logic        ras_active  = 1'b0;

    dda_line_rasterizer i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_stall  (item_stall),
        .item        (item),
        .point_valid (point_valid),
        .point_stall (point_stall),
        .point       (point)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        point_stall <= ($urandom_range(99) < stall_pct);
    end

    task automatic report_mismatch(input string what);
        $display("MISMATCH cycle %0d: %s", cycle_count, what);
        error_count++;
    endtask

    function automatic void rasterize_item(input item_t it);
        coord_t      a1, b1, a2, b2, t, minor;
        int unsigned dx, dy, span, mdiff, q;
        logic        down;
        point_t      p;
        if (it.action == ACT_START)
        begin
            dx = (it.x_start > it.x_end) ? it.x_start - it.x_end : it.x_end - it.x_start;
            dy = (it.y_start > it.y_end) ? it.y_start - it.y_end : it.y_end - it.y_start;
            ras_swapped = (dx < dy);
            if (ras_swapped)
            begin
                a1 = it.y_start; b1 = it.x_start; a2 = it.y_end; b2 = it.x_end;
            end
            else
            begin
                a1 = it.x_start; b1 = it.y_start; a2 = it.x_end; b2 = it.y_end;
            end
            if (a2 < a1)
            begin
                t = a1; a1 = a2; a2 = t;
                t = b1; b1 = b2; b2 = t;
            end
            span  = a2 - a1;
            down  = (b2 < b1);
            mdiff = down ? b1 - b2 : b2 - b1;
            q     = (span != 0) ? (mdiff << FRAC_BITS) / span : 0;
            ras_slope  = down ? -longint'(q) : longint'(q);
            ras_major  = a1;
            ras_acc    = (longint'(b1) << FRAC_BITS) + (longint'(1) << (FRAC_BITS - 1));
            ras_left   = span;
            ras_active = (span != 0);
        end
        else if (ras_active)
        begin
            ras_major = ras_major + 1'b1;
            ras_acc   = ras_acc + ras_slope;
            minor     = coord_t'(ras_acc >>> FRAC_BITS);
            ras_left--;
            p.point_x = ras_swapped ? minor : ras_major;
            p.point_y = ras_swapped ? ras_major : minor;
            p.last    = (ras_left == 0);
            if (ras_left == 0)
                ras_active = 1'b0;
            expected_points.push_back(p);
        end
    endfunction

    always @(posedge clk)
    begin : check_points
        point_t want;
        if (rst_n && point_valid && !point_stall)
        begin
            if (expected_points.size() == 0)
                report_mismatch($sformatf("unexpected point (%0d,%0d) last=%0b",
                                          point.point_x, point.point_y, point.last));
            else
            begin
                want = expected_points.pop_front();
                if (point.point_x !== want.point_x)
                    report_mismatch($sformatf("point_x got %0d want %0d",
                                              point.point_x, want.point_x));
                if (point.point_y !== want.point_y)
                    report_mismatch($sformatf("point_y got %0d want %0d",
                                              point.point_y, want.point_y));
                if (point.last !== want.last)
                    report_mismatch($sformatf("last got %0b want %0b at (%0d,%0d)",
                                              point.last, want.last,
                                              want.point_x, want.point_y));
            end
        end
    end

    function automatic item_t start_item(input int unsigned xa, ya, xb, yb);
        item_t it;
        it.action  = ACT_START;
        it.x_start = coord_t'(xa);
        it.y_start = coord_t'(ya);
        it.x_end   = coord_t'(xb);
        it.y_end   = coord_t'(yb);
        return it;
    endfunction

    function automatic item_t step_item();
        item_t it;
        it = start_item($urandom, $urandom, $urandom, $urandom);
        it.action = ACT_STEP;
        return it;
    endfunction

    task automatic send_item(input item_t it);
        while ($urandom_range(99) < idle_pct)
        begin
            item_valid <= 1'b0;
            item       <= step_item();
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= it;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        rasterize_item(it);
        sent_items++;
    endtask

    task automatic send_steps(input int unsigned n);
        repeat (n)
            send_item(step_item());
    endtask

    task automatic test_idle_and_degenerate();
        send_item(step_item());
        send_item(start_item(5, 5, 5, 5));
        send_item(step_item());
    endtask

    task automatic test_extreme_lines();
        // replace each long line after two points
        send_item(start_item(0, COORD_MAX, COORD_MAX, 0));
        send_steps(2);
        send_item(start_item(10, COORD_MAX, 8, 0));
        send_steps(2);
    endtask

    task automatic test_short_lines();
        send_item(start_item(4, 0, 0, 2));
        send_steps(5);
        send_item(start_item(7, 3, 7, 6));
        send_steps(3);
        send_item(start_item(COORD_MAX - 3, COORD_MAX, COORD_MAX, COORD_MAX));
        send_steps(3);
    endtask

    task automatic run_random_lines(input int unsigned target);
        int unsigned kind, dmax, dx, dy, x0, y0, x1, y1, t, n, span;
        while (sent_items < target)
        begin
            kind = $urandom_range(99);
            if (kind < 6)
                send_item(step_item());
            else if (kind < 10)
            begin
                send_item(start_item($urandom, $urandom, $urandom, $urandom));
                send_steps($urandom_range(0, 6));
            end
            else
            begin
                dmax = ($urandom_range(49) == 0) ? COORD_MAX : 12;
                dx = $urandom_range(0, dmax);
                dy = $urandom_range(0, dmax);
                x0 = $urandom_range(0, COORD_MAX - dx);
                y0 = $urandom_range(0, COORD_MAX - dy);
                x1 = x0 + dx;
                y1 = y0 + dy;
                if ($urandom_range(1))
                begin
                    t = x0; x0 = x1; x1 = t;
                end
                if ($urandom_range(1))
                begin
                    t = y0; y0 = y1; y1 = t;
                end
                span = (dx > dy) ? dx : dy;
                n = ($urandom_range(9) < 7) ? span + $urandom_range(0, 2)
                                            : $urandom_range(0, span);
                if (sent_items + 1 + n > target)
                    n = (target > sent_items + 1) ? target - sent_items - 1 : 0;
                send_item(start_item(x0, y0, x1, y1));
                send_steps(n);
            end
        end
    endtask

    task automatic test_random_lines();
        run_random_lines(sent_items + RANDOM_ITEMS / 3);
        idle_pct  = 0;
        stall_pct = 0;
        run_random_lines(sent_items + RANDOM_ITEMS / 4);
        idle_pct  = 37;
        stall_pct = 37;
        run_random_lines(RANDOM_ITEMS);
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        test_idle_and_degenerate();
        test_extreme_lines();
        test_short_lines();
        test_random_lines();
        item_valid <= 1'b0;
        while (expected_points.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

`default_nettype wire

### dda_line_rasterizer.f
design/dda_pkg.sv
design/dda_front.sv
design/dda_div.sv
design/dda_back.sv
design/dda_line_rasterizer.sv
bench/tb_dda_line_rasterizer.sv
